@@ design/bas_pkg.sv @@
// Shared constants, register indexes and helper functions for the barometric
// altitude smoother. No dependencies; bas_alt_table and the top level use this package.
package bas_pkg;

  localparam int HISTORY_DEPTH_DEF     = 16;
  localparam int ALT_TABLE_ENTRIES_DEF = 64;

  localparam int P_W     = 21;  // pressure sample width, 1/16 Pa
  localparam int ALT_W   = 24;  // altitude and speed width, signed
  localparam int MUL_W   = 26;  // operand width of the shared multiplier
  localparam int DVD_W   = 34;  // dividend width of the shared divider
  localparam int CFG_IW  = 8;   // configuration index width
  localparam int PERIOD_W = 16;

  localparam logic [CFG_IW-1:0] CFG_ZERO_ALT = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_PERIOD   = 8'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd63;

  localparam longint TOP_ALT_CM   = 4433000;
  localparam longint P0_SIXTEENTH = 1621200;
  localparam longint LN2_Q30      = 744261118;
  localparam longint Q30_ONE      = 64'sd1 << 30;

  // Q30 log2 of x; integer part exact, fraction by repeated squaring.
  function automatic longint log2_q30(input longint unsigned x);
    int n;
    longint unsigned m;
    longint frac;
    n = 0;
    frac = 0;
    for (int j = 0; j < 30; j++) begin
      if (n < 30 && (x >> (n + 1)) != 0) n = n + 1;
    end
    m = x << (30 - n);
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'sd1 << (30 - i));
      end
    end
    return longint'(n) * Q30_ONE + frac;
  endfunction

  // 2^(f/2^30) in Q30 through a truncated exponential series.
  function automatic longint unsigned exp2_frac_q30(input longint unsigned f);
    longint unsigned t;
    longint unsigned term;
    longint unsigned acc;
    t = (f * 64'(LN2_Q30)) >> 30;
    term = 64'(Q30_ONE);
    acc = 64'(Q30_ONE);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * t) >> 30) / 64'(n);
      acc = acc + term;
    end
    return acc;
  endfunction

  function automatic longint unsigned pow2_q30(input longint e);
    longint ip;
    longint unsigned f;
    longint unsigned v;
    ip = e >>> 30;
    f = 64'(e) & 64'h3FFF_FFFF;
    v = exp2_frac_q30(f);
    if (ip >= 0) begin
      if (ip > 2) ip = 2;
      v = v << ip;
    end else begin
      if (-ip > 62) return 64'd0;
      v = v >> (-ip);
    end
    return v;
  endfunction

  // Table point k of n: altitude in cm at pressure k*2^21/n (1/16 Pa).
  function automatic logic signed [ALT_W-1:0] alt_entry(input int k, input int n);
    longint base;
    longint l;
    longint e;
    longint unsigned y;
    longint unsigned scaled;
    if (k == 0) return ALT_W'(TOP_ALT_CM);
    base = log2_q30(64'(P0_SIXTEENTH)) + log2_q30(64'(n));
    l = log2_q30(64'(k)) + longint'(P_W) * Q30_ONE - base;
    e = (l * 200) / 1051;
    y = pow2_q30(e);
    scaled = (64'(TOP_ALT_CM) * y + (64'd1 << 29)) >> 30;
    return ALT_W'(TOP_ALT_CM - longint'(scaled));
  endfunction

  // Clamp a wide signed value to the 24-bit signed output range.
  function automatic logic [ALT_W-1:0] sat24(input logic signed [35:0] v);
    if (v > 36'sd8388607) return 24'h7FFFFF;
    if (v < -36'sd8388608) return 24'h800000;
    return v[ALT_W-1:0];
  endfunction

endpackage

@@ design/bas_hist_ram.sv @@
// Pressure history memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module bas_hist_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/bas_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module bas_divider #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/bas_alt_table.sv @@
// Altitude table of N+1 points, built at elaboration from bas_pkg::alt_entry.
// Gives the two points that bracket a segment index.
module bas_alt_table #(
  parameter int N = 64
) (
  input  logic [$clog2(N)-1:0]           idx,
  output logic signed [bas_pkg::ALT_W-1:0] lo,
  output logic signed [bas_pkg::ALT_W-1:0] hi
);

  localparam int TBW = $clog2(N + 1);

  logic signed [bas_pkg::ALT_W-1:0] tbl [N + 1];
  logic [TBW-1:0] idx_lo;
  logic [TBW-1:0] idx_hi;

  for (genvar k = 0; k <= N; k++) begin : g_pt
    assign tbl[k] = bas_pkg::alt_entry(k, N);
  end

  assign idx_lo = TBW'(idx);
  assign idx_hi = TBW'(idx) + TBW'(1);
  assign lo = tbl[idx_lo];
  assign hi = tbl[idx_hi];

endmodule

@@ design/barometric_altimeter_smoother.sv @@
// Top level of the barometric altitude smoother: sequencer, shared multiplier,
// history ring control. Uses bas_pkg, bas_hist_ram, bas_divider, bas_alt_table.
//
//   Channel | Signals                                  | Direction
//   --------+------------------------------------------+-----------
//   input   | in_valid, in_ready, in_pressure_*        | sample in
//   result  | out_valid, out_ready, out_* fields       | result out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Samples are not overlapped: a new sample is accepted only once the previous one is
// finished, and while fewer than two samples are held the speed steps are skipped.
// The processing time is set mostly by the single divider, which forms 34 quotient
// bits per use and serves the mean pressure and both speeds in turn. Reset is
// synchronous and active low; it empties the history and restores the registers.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so a stalled out_ready holds the next result back only once that
// one is done.
module barometric_altimeter_smoother #(
  parameter int HISTORY_DEPTH     = bas_pkg::HISTORY_DEPTH_DEF,
  parameter int ALT_TABLE_ENTRIES = bas_pkg::ALT_TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bas_pkg::P_W-1:0]      in_pressure_sixteenth_pa,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bas_pkg::ALT_W-1:0]    out_altitude_cm,
  output logic [bas_pkg::ALT_W-1:0]    out_smooth_altitude_cm,
  output logic [bas_pkg::ALT_W-1:0]    out_vertical_speed_cms,
  output logic [bas_pkg::ALT_W-1:0]    out_smooth_vertical_speed_cms,
  output logic [4:0]                   out_samples_held,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bas_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bas_pkg::ALT_W-1:0]    cfg_data
);

  localparam int HD    = HISTORY_DEPTH;
  localparam int IW    = $clog2(HD);
  localparam int CW    = $clog2(HD + 1);
  localparam int SW    = bas_pkg::P_W + $clog2(HD);
  localparam int TIW   = $clog2(ALT_TABLE_ENTRIES);
  localparam int PW    = bas_pkg::P_W + TIW;
  localparam int DVS_W = bas_pkg::PERIOD_W + CW;
  localparam int PRW   = 2 * bas_pkg::MUL_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPD    = 4'd1;
  localparam logic [3:0] S_RDPREV = 4'd2;
  localparam logic [3:0] S_RDOLD  = 4'd3;
  localparam logic [3:0] S_MDIV   = 4'd4;
  localparam logic [3:0] S_APOS   = 4'd5;
  localparam logic [3:0] S_AMUL   = 4'd6;
  localparam logic [3:0] S_AACC   = 4'd7;
  localparam logic [3:0] S_SMUL1  = 4'd8;
  localparam logic [3:0] S_SMUL2  = 4'd9;
  localparam logic [3:0] S_SDIV   = 4'd10;
  localparam logic [3:0] S_SWAIT  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] st_r;

  // Configuration registers.
  logic signed [bas_pkg::ALT_W-1:0]  zero_alt_r;
  logic [bas_pkg::PERIOD_W-1:0]      period_r;

  // History ring control.
  logic [IW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          full;

  // Per-item working registers.
  logic [bas_pkg::P_W-1:0] p_r, prev_p_r, old_p_r, mean_p_r;
  logic [PW-1:0]           pos_r;
  logic [1:0]              aj_r;
  logic                    spd_r;
  logic                    neg_r;
  logic [bas_pkg::DVD_W-1:0] dvd_r;
  logic signed [bas_pkg::ALT_W-1:0] lo_r;
  logic signed [bas_pkg::ALT_W-1:0] alt_r [4];
  logic [bas_pkg::ALT_W-1:0] vcur_r, vsm_r;

  // Output register.
  logic                      out_valid_r;
  logic [bas_pkg::ALT_W-1:0] o_alt_r, o_salt_r, o_vs_r, o_svs_r;
  logic [4:0]                o_cnt_r;

  // Memory port.
  logic                    mem_we;
  logic [IW-1:0]           mem_raddr;
  logic [bas_pkg::P_W-1:0] mem_rdata;
  logic [IW-1:0]           prev_addr;
  logic [CW:0]             wp_e, cnt_e, old_e;

  // Shared multiplier.
  logic signed [bas_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [PRW-1:0]            mul_p_r;

  // Shared divider.
  logic                      div_start;
  logic [bas_pkg::DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [bas_pkg::DVD_W-1:0] div_q;

  // Table and interpolation.
  logic signed [bas_pkg::ALT_W-1:0] t_lo, t_hi;
  logic [bas_pkg::P_W-1:0]          alt_p;
  logic signed [PRW-1:0]            interp_adj;
  logic signed [PRW-1:0]            interp_q;
  logic signed [bas_pkg::ALT_W:0]   alt_sum;

  // Speed support.
  logic [bas_pkg::PERIOD_W-1:0]     period_eff;
  logic signed [bas_pkg::ALT_W:0]   alt_diff;
  logic signed [PRW-1:0]            prod_mag;
  logic signed [35:0]               q_signed;
  logic                             done_go;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Ring bookkeeping for the sample taken in S_UPD.
  assign full    = (cnt_r == CW'(HD));
  assign sum_nxt = sum_r - (full ? SW'(mem_rdata) : SW'(0)) + SW'(p_r);
  assign cnt_nxt = full ? cnt_r : cnt_r + 1'b1;
  assign wp_nxt  = (wp_r == IW'(HD - 1)) ? '0 : wp_r + 1'b1;
  assign prev_addr = (wp_r == '0) ? IW'(HD - 1) : wp_r - 1'b1;

  // Oldest slot: new write pointer minus the new count, modulo the depth.
  assign wp_e  = (CW + 1)'(wp_r);
  assign cnt_e = (CW + 1)'(cnt_r);
  assign old_e = (wp_e >= cnt_e) ? wp_e - cnt_e : wp_e + (CW + 1)'(HD) - cnt_e;

  assign mem_we = (st_r == S_UPD);

  always_comb begin
    case (st_r)
      S_UPD:    mem_raddr = prev_addr;
      S_RDPREV: mem_raddr = old_e[IW-1:0];
      default:  mem_raddr = wp_r;
    endcase
  end

  bas_hist_ram #(
    .DEPTH(HD),
    .WIDTH(bas_pkg::P_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wp_r),
    .wdata(p_r),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bas_alt_table #(
    .N(ALT_TABLE_ENTRIES)
  ) u_table (
    .idx(pos_r[PW-1:bas_pkg::P_W]),
    .lo (t_lo),
    .hi (t_hi)
  );

  // Operand selection for the one multiplier: interpolation in S_AMUL, the
  // altitude difference times 1000 in S_SMUL1, period times the sample gap in
  // S_SMUL2.
  assign period_eff = (period_r == '0) ? bas_pkg::PERIOD_W'(1) : period_r;
  assign alt_diff   = {alt_r[0][bas_pkg::ALT_W-1], alt_r[0]}
                    - (spd_r ? {alt_r[3][bas_pkg::ALT_W-1], alt_r[3]}
                             : {alt_r[2][bas_pkg::ALT_W-1], alt_r[2]});

  always_comb begin
    case (st_r)
      S_AMUL: begin
        mul_a = bas_pkg::MUL_W'(t_hi) - bas_pkg::MUL_W'(t_lo);
        mul_b = $signed(bas_pkg::MUL_W'(pos_r[bas_pkg::P_W-1:0]));
      end
      S_SMUL1: begin
        mul_a = bas_pkg::MUL_W'(alt_diff);
        mul_b = bas_pkg::MUL_W'(1000);
      end
      S_SMUL2: begin
        mul_a = $signed(bas_pkg::MUL_W'(period_eff));
        mul_b = spd_r ? $signed(bas_pkg::MUL_W'(cnt_r - 1'b1)) : bas_pkg::MUL_W'(1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // The interpolation step rounds toward zero, so negative products are
  // biased up by one less than the divisor before the shift.
  assign interp_adj = mul_p_r + (mul_p_r[PRW-1] ? PRW'((1 << bas_pkg::P_W) - 1) : PRW'(0));
  assign interp_q   = interp_adj >>> bas_pkg::P_W;
  assign alt_sum    = {lo_r[bas_pkg::ALT_W-1], lo_r} + interp_q[bas_pkg::ALT_W:0];

  assign prod_mag = mul_p_r[PRW-1] ? -mul_p_r : mul_p_r;
  assign q_signed = neg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

  always_comb begin
    case (aj_r)
      2'd0:    alt_p = p_r;
      2'd1:    alt_p = mean_p_r;
      2'd2:    alt_p = prev_p_r;
      default: alt_p = old_p_r;
    endcase
  end

  // Divider serves the mean pressure first, then both speeds.
  assign div_start = (st_r == S_RDOLD) || (st_r == S_SDIV);
  assign div_dvd   = (st_r == S_RDOLD) ? bas_pkg::DVD_W'(sum_r) : dvd_r;
  assign div_dvs   = (st_r == S_RDOLD) ? DVS_W'(cnt_r) : mul_p_r[DVS_W-1:0];

  bas_divider #(
    .DVD_W(bas_pkg::DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  assign done_go = (st_r == S_DONE) && (!out_valid_r || out_ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_alt_r <= '0;
      period_r   <= bas_pkg::PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bas_pkg::CFG_ZERO_ALT: zero_alt_r <= cfg_data;
        bas_pkg::CFG_PERIOD:   period_r   <= cfg_data[bas_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and ring control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      wp_r  <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      aj_r  <= '0;
      spd_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_valid) st_r <= S_UPD;
        end
        S_UPD: begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
          wp_r  <= wp_nxt;
          st_r  <= S_RDPREV;
        end
        S_RDPREV: st_r <= S_RDOLD;
        S_RDOLD:  st_r <= S_MDIV;
        S_MDIV: begin
          if (div_done) begin
            aj_r <= '0;
            st_r <= S_APOS;
          end
        end
        S_APOS: st_r <= S_AMUL;
        S_AMUL: st_r <= S_AACC;
        S_AACC: begin
          aj_r <= aj_r + 1'b1;
          if (aj_r != 2'd3) begin
            st_r <= S_APOS;
          end else if (cnt_r < CW'(2)) begin
            st_r <= S_DONE;
          end else begin
            spd_r <= 1'b0;
            st_r  <= S_SMUL1;
          end
        end
        S_SMUL1: st_r <= S_SMUL2;
        S_SMUL2: st_r <= S_SDIV;
        S_SDIV:  st_r <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            if (!spd_r) begin
              spd_r <= 1'b1;
              st_r  <= S_SMUL1;
            end else begin
              st_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_go) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Working data path registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) p_r <= in_pressure_sixteenth_pa;
    if (st_r == S_RDPREV) prev_p_r <= mem_rdata;
    if (st_r == S_RDOLD)  old_p_r  <= mem_rdata;
    if (st_r == S_MDIV && div_done) mean_p_r <= div_q[bas_pkg::P_W-1:0];
    if (st_r == S_APOS) pos_r <= PW'(alt_p) * PW'(ALT_TABLE_ENTRIES);
    if (st_r == S_AMUL) lo_r <= t_lo;
    if (st_r == S_AACC) alt_r[aj_r] <= alt_sum[bas_pkg::ALT_W-1:0];
    if (st_r == S_AACC && cnt_r < CW'(2)) begin
      vcur_r <= '0;
      vsm_r  <= '0;
    end
    if (st_r == S_SMUL2) begin
      neg_r <= mul_p_r[PRW-1];
      dvd_r <= prod_mag[bas_pkg::DVD_W-1:0];
    end
    if (st_r == S_SWAIT && div_done) begin
      if (spd_r) vsm_r  <= bas_pkg::sat24(q_signed);
      else       vcur_r <= bas_pkg::sat24(q_signed);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      o_alt_r  <= bas_pkg::sat24(36'(alt_r[0]) - 36'(zero_alt_r));
      o_salt_r <= bas_pkg::sat24(36'(alt_r[1]) - 36'(zero_alt_r));
      o_vs_r   <= vcur_r;
      o_svs_r  <= vsm_r;
      o_cnt_r  <= 5'(cnt_r);
    end
  end

  assign out_valid                     = out_valid_r;
  assign out_altitude_cm               = o_alt_r;
  assign out_smooth_altitude_cm        = o_salt_r;
  assign out_vertical_speed_cms        = o_vs_r;
  assign out_smooth_vertical_speed_cms = o_svs_r;
  assign out_samples_held              = o_cnt_r;

  // An accepted sample always starts the ring update next.
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == S_UPD))
    else $error("accepted sample did not start the ring update");

  // The count never passes the ring depth and the pointer stays in range.
  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(HD)) && (wp_r <= IW'(HD - 1)))
    else $error("ring count or pointer out of range");

  // A new result only appears when the sequencer has finished an item.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == S_DONE))
    else $error("result raised outside the finishing step");

  // A presented result always covers at least one held sample.
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r != '0))
    else $error("result presented with an empty history");

endmodule
